// ===== sv/rea_pkg.sv =====
// shared types, constants and the quadrature transition table
`default_nettype none
package rea_pkg;

  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned DIV_W = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ_CHG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PRIME    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 3'd5;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  localparam logic [31:0] ACCEL_WINDOW_US = 32'd150000;
  localparam logic [9:0]  ACCEL_SCALE     = 10'd1000;
  localparam logic [6:0]  BONUS_CAP       = 7'd100;

  typedef struct packed {
    logic               enable;
    logic [7:0]         steps;
    logic [15:0]        coef;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               wrap;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [1:0]         pair;
    logic [31:0]        now_us;
    logic signed [31:0] new_position;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic signed [1:0] quad_val(input logic [3:0] hist);
    logic signed [1:0] v;
    unique case (hist)
      4'd1, 4'd7, 4'd8, 4'd14: v = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: v = 2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rea_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module rea_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [rea_pkg::DIV_W-1:0] dividend,
  input  wire logic [rea_pkg::DIV_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [rea_pkg::DIV_W-1:0]   quo,
  output logic [rea_pkg::DIV_W-1:0]   rem
);
  localparam int unsigned W = rea_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
        quo_r <= {quo_r[W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ===== sv/rea_front.sv =====
// input side: accepts beats, drops ones with no effect, two-entry queue
`default_nettype none
module rea_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               enable,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rea_pkg::item_t     in_item,
  input  wire logic               pop,
  output rea_pkg::item_t          head,
  output rea_pkg::q_status_t      status
);
  localparam int unsigned D = rea_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(D);

  rea_pkg::item_t ent_r [D];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    cnt_r;
  logic           keep, push;

  // unused codes and samples while disabled never reach the back end
  assign keep = (in_item.cmd <= rea_pkg::CMD_PRIME) &&
                !(in_item.cmd == rea_pkg::CMD_SAMPLE && !enable);
  assign in_ready = cnt_r != (AW+1)'(D);
  assign push = in_valid && in_ready && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= in_item;
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  assign head = ent_r[rd_ptr_r];
  assign status.full  = !in_ready;
  assign status.empty = cnt_r == '0;
endmodule
`default_nettype wire

// ===== sv/rea_back.sv =====
// execution side: decoder state, detent division, acceleration, bounds
`default_nettype none
module rea_back #(
  parameter int unsigned POS_WIDTH = rea_pkg::POS_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rea_pkg::cfg_t      cfg,
  input  wire rea_pkg::item_t     head,
  input  wire rea_pkg::q_status_t qst,
  output logic                    pop,
  output logic                    div_start,
  output logic [rea_pkg::DIV_W-1:0] div_dividend,
  output logic [rea_pkg::DIV_W-1:0] div_divisor,
  input  wire logic               div_done,
  input  wire logic [rea_pkg::DIV_W-1:0] div_quo,
  input  wire logic [rea_pkg::DIV_W-1:0] div_rem,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_position,
  output logic signed [31:0]      out_change
);
  localparam int unsigned P = POS_WIDTH;
  localparam int unsigned IW = 34;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV1, S_DIV2, S_ADD, S_BOUND, S_FIN, S_OUT
  } state_t;

  state_t             state_r;
  rea_pkg::item_t     ent_r;
  logic [3:0]         hist_r;
  logic signed [31:0] raw_r, resid_r, rsum_r;
  logic [31:0]        time_r;
  logic [1:0]         dir_r;
  logic signed [P-1:0] pos_r, last_r;
  logic signed [IW-1:0] inc_r;
  logic signed [31:0] chg_r;
  logic               ov_r;

  logic [3:0]          hist_nxt;
  logic signed [P-1:0] mx, mn, np, np_lo;
  logic signed [31:0]  res_base, rsum;
  logic                rneg;
  logic signed [IW-1:0] steps;
  logic [1:0]          dir;
  logic [31:0]         elapsed;
  logic                accel;
  logic [6:0]          bonus;

  assign mx = P'(cfg.max_value);
  assign mn = P'(cfg.min_value);
  assign np = P'(head.new_position);
  assign np_lo = (mx < np) ? mx : np;
  assign hist_nxt = {hist_r[1:0], head.pair};

  // residual is dropped when the new motion reverses it
  assign res_base = ((raw_r > 0 && resid_r < 0) || (raw_r < 0 && resid_r > 0)) ? '0 : resid_r;
  assign rsum = res_base + raw_r;
  assign rneg = rsum_r[31];

  assign steps = rneg ? -IW'($signed({1'b0, div_quo})) : IW'($signed({1'b0, div_quo}));
  assign dir = rneg ? rea_pkg::DIR_NEG : rea_pkg::DIR_POS;
  assign elapsed = ent_r.now_us - time_r;
  assign accel = cfg.coef > 16'd1 && dir == dir_r && elapsed != '0 &&
                 elapsed < rea_pkg::ACCEL_WINDOW_US;
  assign bonus = (div_quo > 32'(rea_pkg::BONUS_CAP)) ? rea_pkg::BONUS_CAP : div_quo[6:0];

  assign pop = state_r == S_IDLE && !qst.empty;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (pop && (head.cmd == rea_pkg::CMD_READ || head.cmd == rea_pkg::CMD_READ_CHG) &&
        cfg.enable && raw_r != '0) begin
      div_start    = 1'b1;
      div_dividend = rsum[31] ? 32'(-rsum) : 32'(rsum);
      div_divisor  = (cfg.steps == '0) ? 32'd1 : 32'(cfg.steps);
    end else if (state_r == S_DIV1 && div_done && div_quo != '0 && accel) begin
      div_start    = 1'b1;
      div_dividend = 32'(cfg.coef) * 32'(rea_pkg::ACCEL_SCALE);
      div_divisor  = elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      hist_r  <= '0;
      raw_r   <= '0;
      resid_r <= '0;
      pos_r   <= '0;
      last_r  <= '0;
      time_r  <= '0;
      dir_r   <= rea_pkg::DIR_NONE;
    end else begin
      if (state_r == S_OUT && (!ov_r || out_ready)) begin
        ov_r         <= 1'b1;
        out_position <= 32'(pos_r);
        out_change   <= chg_r;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            ent_r <= head;
            chg_r <= '0;
            priority case (head.cmd)
              rea_pkg::CMD_SAMPLE: begin
                hist_r <= hist_nxt;
                raw_r  <= raw_r + 32'(rea_pkg::quad_val(hist_nxt));
              end
              rea_pkg::CMD_SET: begin
                raw_r   <= '0;
                resid_r <= '0;
                pos_r   <= (np_lo < mn) ? mn : np_lo;
                last_r  <= (np_lo < mn) ? mn : np_lo;
                state_r <= S_OUT;
              end
              rea_pkg::CMD_PRIME: begin
                hist_r  <= {head.pair, head.pair};
                last_r  <= '0;
                state_r <= S_OUT;
              end
              default: begin
                if (cfg.enable) raw_r <= '0;
                if (div_start) begin
                  rsum_r  <= rsum;
                  state_r <= S_DIV1;
                end else begin
                  state_r <= S_FIN;
                end
              end
            endcase
          end
        end
        S_DIV1: begin
          if (div_done) begin
            resid_r <= rneg ? -$signed(div_rem) : $signed(div_rem);
            if (div_quo == '0) begin
              state_r <= S_FIN;
            end else begin
              inc_r   <= steps;
              time_r  <= ent_r.now_us;
              dir_r   <= dir;
              state_r <= accel ? S_DIV2 : S_ADD;
            end
          end
        end
        S_DIV2: begin
          if (div_done) begin
            inc_r   <= rneg ? inc_r - IW'(bonus) : inc_r + IW'(bonus);
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          pos_r   <= pos_r + P'(inc_r);
          state_r <= S_BOUND;
        end
        S_BOUND: begin
          if (mx < pos_r) begin
            pos_r <= cfg.wrap ? mn + (pos_r - mx - P'(1)) : mx;
          end else if (pos_r < mn) begin
            pos_r <= cfg.wrap ? mx - (mn - pos_r - P'(1)) : mn;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (ent_r.cmd == rea_pkg::CMD_READ_CHG) begin
            chg_r  <= 32'(pos_r - last_r);
            last_r <= pos_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ov_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

// ===== sv/rotary_encoder_accel_position.sv =====
// top level: configuration registers, front queue, back end and divider
`default_nettype none
// Quadrature encoder decoder with detent scaling, acceleration and a bounded
// or wrapping position. Items enter a two-entry queue; the back end runs one
// at a time. A pin sample is handled in the idle state and gives no beat;
// set and prime go straight to the output state. A read with motion runs
// the shared divider once for the detent division, and once more for the
// speed bonus when it applies. Reads with no pending motion, or while
// disabled, go through the finish state to the output. Out-of-range
// commands and samples while disabled are dropped at the input.
module rotary_encoder_accel_position #(
  parameter int unsigned POS_WIDTH = rea_pkg::POS_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [rea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rea_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_cmd,
  input  wire logic                in_pin_a,
  input  wire logic                in_pin_b,
  input  wire logic [31:0]         in_now_us,
  input  wire logic signed [31:0]  in_new_position,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_position,
  output logic signed [31:0]       out_change
);
  rea_pkg::cfg_t      cfg_r;
  rea_pkg::item_t     in_item, head;
  rea_pkg::q_status_t qst;
  logic               pop, div_start, div_busy, div_done;
  logic [rea_pkg::DIV_W-1:0] div_dividend, div_divisor, div_quo, div_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.steps     <= 8'd4;
      cfg_r.coef      <= '0;
      cfg_r.min_value <= '0;
      cfg_r.max_value <= 32'sd100;
      cfg_r.wrap      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rea_pkg::REG_ENABLE: cfg_r.enable    <= cfg_wdata[0];
        rea_pkg::REG_STEPS:  cfg_r.steps     <= cfg_wdata[7:0];
        rea_pkg::REG_COEF:   cfg_r.coef      <= cfg_wdata[15:0];
        rea_pkg::REG_MIN:    cfg_r.min_value <= $signed(cfg_wdata);
        rea_pkg::REG_MAX:    cfg_r.max_value <= $signed(cfg_wdata);
        rea_pkg::REG_WRAP:   cfg_r.wrap      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_item.cmd          = in_cmd;
  assign in_item.pair         = {in_pin_b, in_pin_a};
  assign in_item.now_us       = in_now_us;
  assign in_item.new_position = in_new_position;

  rea_front u_front (
    .clk(clk), .rst_n(rst_n), .enable(cfg_r.enable),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .pop(pop), .head(head), .status(qst)
  );

  rea_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_dividend), .divisor(div_divisor),
    .busy(div_busy), .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  rea_back #(.POS_WIDTH(POS_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .head(head), .qst(qst), .pop(pop),
    .div_start(div_start), .div_dividend(div_dividend), .div_divisor(div_divisor),
    .div_done(div_done), .div_quo(div_quo), .div_rem(div_rem),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_position(out_position), .out_change(out_change)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qst.empty) else $error("pop from empty queue");
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(qst.full && qst.empty)) else $error("queue full and empty");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_busy) else $error("divider done while busy");
endmodule
`default_nettype wire

// ===== dv/rotary_encoder_accel_position_tb.sv =====
// self-checking testbench for the quadrature decoder with acceleration and bounds
`timescale 1ns / 100ps
`default_nettype none
module rotary_encoder_accel_position_tb;

  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 150;

  logic clk, rst_n;
  logic cfg_we;
  logic [rea_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rea_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_pin_a, in_pin_b, out_valid, out_ready;
  logic [2:0] in_cmd;
  logic [31:0] in_now_us;
  logic signed [31:0] in_new_position, out_position, out_change;

  rotary_encoder_accel_position dut (.*);

  typedef struct {
    logic [2:0]  cmd;
    bit          a, b;
    logic [31:0] now;
    logic [31:0] npos;
    bit          typed;
    logic [31:0] epos, echg;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] pos, chg;
  } enc_result_t;

  enc_result_t pending_q[$];
  int errors = 0, results_seen = 0, items_sent = 0;
  int send_idle = 0, recv_stall = 0, hold_left = 0;

  // shadow copy of the block
  bit          m_en, m_wrap;
  logic [7:0]  m_steps;
  logic [15:0] m_coef;
  logic [31:0] m_min, m_max;
  logic [3:0]  m_hist;
  logic [31:0] m_raw, m_resid, m_pos, m_last_read, m_last_time;
  logic [1:0]  m_dir;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d (beat %0d)", what, $signed(got),
             $signed(want), results_seen);
    errors++;
  endtask

  function automatic int quad_step(logic [3:0] h);
    case (h)
      4'd1, 4'd7, 4'd8, 4'd14: return -1;
      4'd2, 4'd4, 4'd11, 4'd13: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic apply_motion(logic [31:0] now);
    int raw, res, spd, steps;
    logic [31:0] inc, elapsed, bonus;
    logic [1:0] dir;
    if (!m_en) return;
    raw = m_raw;
    m_raw = 0;
    if (raw == 0) return;
    res = m_resid;
    if ((raw > 0 && res < 0) || (raw < 0 && res > 0)) res = 0;
    res = res + raw;
    spd = (m_steps == 0) ? 1 : int'(m_steps);
    steps = res / spd;
    if (steps == 0) begin
      m_resid = res;
      return;
    end
    m_resid = res - steps * spd;
    dir = (steps > 0) ? rea_pkg::DIR_POS : rea_pkg::DIR_NEG;
    inc = steps;
    if (m_coef > 1 && dir == m_dir) begin
      elapsed = now - m_last_time;
      if (elapsed > 0 && elapsed < 32'd150000) begin
        bonus = (32'(m_coef) * 32'd1000) / elapsed;
        if (bonus > 32'd100) bonus = 32'd100;
        inc = (dir == rea_pkg::DIR_POS) ? inc + bonus : inc - bonus;
      end
    end
    m_last_time = now;
    m_dir = dir;
    m_pos = m_pos + inc;
    if ($signed(m_max) < $signed(m_pos)) begin
      m_pos = m_wrap ? m_min + (m_pos - m_max - 1) : m_max;
    end else if ($signed(m_pos) < $signed(m_min)) begin
      m_pos = m_wrap ? m_max - (m_min - m_pos - 1) : m_min;
    end
  endtask

  task automatic predict(stim_row_t r, output bit has, output enc_result_t res);
    logic [1:0] pair;
    pair = {r.b, r.a};
    has = 1;
    res.chg = 0;
    case (r.cmd)
      rea_pkg::CMD_SAMPLE: begin
        has = 0;
        if (m_en) begin
          m_hist = {m_hist[1:0], pair};
          m_raw = m_raw + quad_step(m_hist);
        end
      end
      rea_pkg::CMD_READ: apply_motion(r.now);
      rea_pkg::CMD_READ_CHG: begin
        apply_motion(r.now);
        res.chg = m_pos - m_last_read;
        m_last_read = m_pos;
      end
      rea_pkg::CMD_SET: begin
        m_raw = 0;
        m_resid = 0;
        m_pos = r.npos;
        if ($signed(m_max) < $signed(m_pos)) m_pos = m_max;
        if ($signed(m_pos) < $signed(m_min)) m_pos = m_min;
        m_last_read = m_pos;
      end
      rea_pkg::CMD_PRIME: begin
        m_hist = {pair, pair};
        m_last_read = 0;
      end
      default: has = 0;
    endcase
    res.pos = m_pos;
  endtask

  task automatic write_reg(logic [rea_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    case (idx)
      rea_pkg::REG_ENABLE: m_en = val[0];
      rea_pkg::REG_STEPS:  m_steps = val[7:0];
      rea_pkg::REG_COEF:   m_coef = val[15:0];
      rea_pkg::REG_MIN:    m_min = val;
      rea_pkg::REG_MAX:    m_max = val;
      rea_pkg::REG_WRAP:   m_wrap = val[0];
      default: ;
    endcase
  endtask

  // drains all results, then lets a trailing sample finish in the back end
  task automatic drain_block();
    in_valid <= 0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(stim_row_t r);
    bit has;
    enc_result_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_cmd <= r.cmd;
    in_pin_a <= r.a;
    in_pin_b <= r.b;
    in_now_us <= r.now;
    in_new_position <= r.npos;
    do @(posedge clk); while (!in_ready);
    predict(r, has, res);
    if (r.typed) begin
      res.pos = r.epos;
      res.chg = r.echg;
    end
    if (has) pending_q.push_back(res);
    if (r.cmd < CMD_SPARE_LO) items_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report("unexpected beat", out_position, 0);
      end else begin
        if (out_position !== pending_q[0].pos) report("position", out_position, pending_q[0].pos);
        if (out_change !== pending_q[0].chg) report("change", out_change, pending_q[0].chg);
        void'(pending_q.pop_front());
      end
    end
  end

  // receiver side, long hold-offs counted here
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // random stimulus generator state
  int gray_idx = 0, spin = 1;
  logic [31:0] clock_us = 0;
  const logic [1:0] gray_seq[4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  function automatic stim_row_t make_random();
    stim_row_t r;
    int pick;
    r = '{default: 0};
    r.now = $urandom;
    r.npos = $urandom;
    r.a = $urandom_range(1);
    r.b = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 55) begin
      r.cmd = rea_pkg::CMD_SAMPLE;
      if ($urandom_range(99) < 8) spin = -spin;
      if ($urandom_range(99) >= 6) begin
        gray_idx = (gray_idx + spin + 4) % 4;
        {r.b, r.a} = gray_seq[gray_idx];
      end
    end else if (pick < 82) begin
      r.cmd = $urandom_range(1) ? rea_pkg::CMD_READ_CHG : rea_pkg::CMD_READ;
      pick = $urandom_range(99);
      if (pick < 70) clock_us = clock_us + $urandom_range(2000, 1);
      else if (pick < 80) clock_us = clock_us + $urandom_range(200000, 100000);
      else if (pick < 90) clock_us = $urandom;
      r.now = clock_us;
    end else if (pick < 90) begin
      r.cmd = rea_pkg::CMD_SET;
      if ($urandom_range(1)) r.npos = m_min + $urandom_range(6) - 3;
      else if ($urandom_range(1)) r.npos = m_max + $urandom_range(6) - 3;
    end else if (pick < 96) begin
      r.cmd = rea_pkg::CMD_PRIME;
      gray_idx = $urandom_range(3);
      {r.b, r.a} = gray_seq[gray_idx];
    end else begin
      r.cmd = $urandom_range(CMD_SPARE_HI, CMD_SPARE_LO);
    end
    return r;
  endfunction

  stim_row_t dir_rows[26];

  initial begin
    int goal;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_cmd = 0;
    in_pin_a = 0;
    in_pin_b = 0;
    in_now_us = 0;
    in_new_position = 0;
    m_en = 0; m_steps = 4; m_coef = 0; m_min = 0; m_max = 100; m_wrap = 0;
    m_hist = 0; m_raw = 0; m_resid = 0; m_pos = 0; m_last_read = 0;
    m_last_time = 0; m_dir = rea_pkg::DIR_NONE;

    dir_rows[0]  = '{rea_pkg::CMD_READ,     0, 0, 32'd5,   0, 1, 0, 0};
    dir_rows[1]  = '{rea_pkg::CMD_SAMPLE,   1, 1, 0,       0, 0, 0, 0};
    dir_rows[2]  = '{rea_pkg::CMD_SET,      0, 0, 0,       32'd200, 1, 32'd100, 0};
    dir_rows[3]  = '{rea_pkg::CMD_SET,      0, 0, 0,       -32'sd5, 1, 0, 0};
    dir_rows[4]  = '{rea_pkg::CMD_PRIME,    0, 0, 0,       0, 1, 0, 0};
    for (int i = 0; i < 8; i++) begin
      dir_rows[5 + i] = '{rea_pkg::CMD_SAMPLE, gray_seq[(i + 1) % 4][0],
                          gray_seq[(i + 1) % 4][1], 0, 0, 0, 0, 0};
    end
    dir_rows[13] = '{rea_pkg::CMD_READ_CHG, 0, 0, 32'd1000, 0, 0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      dir_rows[14 + i] = '{rea_pkg::CMD_SAMPLE, gray_seq[(i + 1) % 4][0],
                           gray_seq[(i + 1) % 4][1], 0, 0, 0, 0, 0};
    end
    dir_rows[18] = '{rea_pkg::CMD_READ_CHG, 1, 1, 32'hffffffff, 32'hffffffff, 0, 0, 0};
    dir_rows[19] = '{rea_pkg::CMD_SAMPLE,   1, 0, 0, 0, 0, 0, 0};
    dir_rows[20] = '{rea_pkg::CMD_SAMPLE,   1, 1, 0, 0, 0, 0, 0};
    dir_rows[21] = '{rea_pkg::CMD_READ,     0, 0, 32'd1200, 0, 0, 0, 0};
    dir_rows[22] = '{CMD_SPARE_LO, 1, 1, 0, 0, 0, 0, 0};
    dir_rows[23] = '{CMD_SPARE_HI, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[24] = '{rea_pkg::CMD_SET,      0, 0, 0, 32'h7fffffff, 1, 32'd100, 0};
    dir_rows[25] = '{rea_pkg::CMD_SET,      1, 1, 0, 32'h80000000, 1, 0, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (i == 3) begin
        drain_block();
        write_reg(rea_pkg::REG_ENABLE, 1);
      end
      send_item(dir_rows[i]);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      case (ph)
        0: begin
          write_reg(rea_pkg::REG_STEPS, 4); write_reg(rea_pkg::REG_COEF, 0);
          write_reg(rea_pkg::REG_MIN, 0); write_reg(rea_pkg::REG_MAX, 100);
          write_reg(rea_pkg::REG_WRAP, 0);
          send_idle = 0; recv_stall = 0;
        end
        1: begin
          write_reg(rea_pkg::REG_STEPS, 1); write_reg(rea_pkg::REG_COEF, 65535);
          write_reg(rea_pkg::REG_MIN, -50); write_reg(rea_pkg::REG_MAX, 50);
          write_reg(rea_pkg::REG_WRAP, 1);
          send_idle = 88; recv_stall = 0;
        end
        2: begin
          write_reg(rea_pkg::REG_STEPS, 255); write_reg(rea_pkg::REG_COEF, 300);
          write_reg(rea_pkg::REG_MIN, 32'h80000000);
          write_reg(rea_pkg::REG_MAX, 32'h7fffffff);
          write_reg(rea_pkg::REG_WRAP, 0);
          send_idle = 0; recv_stall = 88;
          hold_left = 600;
        end
        3: begin
          write_reg(rea_pkg::REG_STEPS, 0); write_reg(rea_pkg::REG_COEF, 2);
          write_reg(rea_pkg::REG_MIN, -10); write_reg(rea_pkg::REG_MAX, 10);
          write_reg(rea_pkg::REG_WRAP, 1);
          send_idle = 6; recv_stall = 6;
        end
        4: begin
          write_reg(rea_pkg::REG_ENABLE, 0); write_reg(rea_pkg::REG_STEPS, 3);
          send_idle = 0; recv_stall = 88;
        end
        default: begin
          write_reg(rea_pkg::REG_ENABLE, 1); write_reg(rea_pkg::REG_STEPS, 2);
          write_reg(rea_pkg::REG_COEF, 1);
          write_reg(rea_pkg::REG_MIN, 32'h80000000);
          write_reg(rea_pkg::REG_MAX, 32'h7fffffff);
          write_reg(rea_pkg::REG_WRAP, 1);
          send_idle = 0; recv_stall = 0;
        end
      endcase
      goal = items_sent + 150;
      while (items_sent < goal) begin
        if (ph == 3 && items_sent == goal - 75) drain_block();
        send_item(make_random());
      end
    end

    in_valid <= 0;
    for (int w = 0; w < 200000 && pending_q.size() != 0; w++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_q.size() != 0) report("missing beats", pending_q.size(), 0);
    $display("covered %0d items and %0d result beats over six register settings,",
             items_sent, results_seen);
    $display("with clamp and wrap bounds, acceleration, stalls and back-pressure");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
